[hdl/eayu_pkg.sv]
// Shared types and constants for the yaw unwrapper.
// No dependencies; imported by eayu_deg_conv, euler_angle_yaw_unwrapper and the bench.
`timescale 1ns / 1ps
`default_nettype none

package eayu_pkg;

  localparam int RadW  = 16;  // Q2.13 radians
  localparam int DegW  = 15;  // 1/64 degree, roll and pitch
  localparam int UyW   = 23;  // unwrapped yaw
  localparam int TurnW = 8;
  localparam int QuadW = 3;
  localparam int CfgIdxW = 2;

  localparam int ProdW    = 36;
  localparam int DegShift = 20;
  localparam logic signed [20:0]      DegMul    = 21'sd469367;
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(64'sd1 <<< (DegShift - 1));

  localparam logic signed [DegW-1:0] HalfCircle    = 15'sd11520;
  localparam logic signed [DegW-1:0] QuarterCircle = 15'sd5760;
  localparam logic signed [UyW-1:0]  FullCircle    = 23'sd23040;
  localparam logic signed [TurnW-1:0] TurnLimit    = 8'sd127;

  // Quadrant codes
  localparam logic [QuadW-1:0] QuadNone = 3'd0;
  localparam logic [QuadW-1:0] Quad1    = 3'd1;
  localparam logic [QuadW-1:0] Quad2    = 3'd2;
  localparam logic [QuadW-1:0] Quad3    = 3'd3;
  localparam logic [QuadW-1:0] Quad4    = 3'd4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgInvertRoll  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInvertPitch = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInvertYaw   = 2'd2;

  typedef struct packed {
    logic invert_roll;
    logic invert_pitch;
    logic invert_yaw;
  } cfg_t;

endpackage

`default_nettype wire

[hdl/euler_angle_yaw_unwrapper.sv]
// Beats pass the input, degree and result registers. Throughput: one sample per cycle
// unless the output is held; a stage then stalls only when all stages after it are full.
// The degree multipliers sit between input and degree registers; fold, quadrant, turn
// counter and unwrap sit between degree and result registers.
// Reset clears valids, config, turn count, quadrant and the first-sample flag.
`timescale 1ns / 1ps
`default_nettype none

module euler_angle_yaw_unwrapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [eayu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [0:0]                    cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // roll_rad[15:0], pitch_rad[31:16], yaw_rad[47:32]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // roll_deg[14:0], pitch_deg[29:15],
                                     // yaw_unwrapped_deg[52:30], turn_count[60:53], zero
);
  import eayu_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgInvertRoll:  cfg_q.invert_roll  <= cfg_data_i[0];
        CfgInvertPitch: cfg_q.invert_pitch <= cfg_data_i[0];
        CfgInvertYaw:   cfg_q.invert_yaw   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic in_valid_q, deg_valid_q, out_valid_q;
  logic out_ready, deg_ready, in_ready;
  logic step;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign deg_ready     = !deg_valid_q || out_ready;
  assign in_ready      = !in_valid_q  || deg_ready;
  assign s_axis_tready = in_ready;
  assign step          = deg_valid_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      deg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready)  in_valid_q  <= s_axis_tvalid;
      if (deg_ready) deg_valid_q <= in_valid_q;
      if (out_ready) out_valid_q <= deg_valid_q;
    end
  end

  // ---------------- input register ----------------
  logic signed [RadW-1:0] roll_rad_q, pitch_rad_q, yaw_rad_q;

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      roll_rad_q  <= $signed(s_axis_tdata[15:0]);
      pitch_rad_q <= $signed(s_axis_tdata[31:16]);
      yaw_rad_q   <= $signed(s_axis_tdata[47:32]);
    end
  end

  // ---------------- degree conversion ----------------
  logic signed [DegW-1:0] roll_d, pitch_d, yaw_d;
  logic signed [DegW-1:0] roll_q, pitch_q, yaw_q;

  eayu_deg_conv u_conv_roll  (.rad_i(roll_rad_q),  .deg_o(roll_d));
  eayu_deg_conv u_conv_pitch (.rad_i(pitch_rad_q), .deg_o(pitch_d));
  eayu_deg_conv u_conv_yaw   (.rad_i(yaw_rad_q),   .deg_o(yaw_d));

  always_ff @(posedge clk_i) begin
    if (deg_ready && in_valid_q) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
    end
  end

  // ---------------- fold, quadrant, turns, unwrap ----------------
  logic                    first_q;
  logic signed [DegW-1:0]  init_yaw_q;
  logic [QuadW-1:0]        quad_q, quad_d;
  logic signed [TurnW-1:0] turn_q, turn_d;

  logic signed [DegW-1:0]  roll_fold, roll_out, pitch_out;
  logic signed [DegW-1:0]  init_eff;
  logic signed [UyW-1:0]   uy_raw, uy_out;

  always_comb begin
    if (roll_q > 0) begin
      roll_fold = HalfCircle - roll_q;
    end else begin
      roll_fold = -HalfCircle - roll_q;
    end
    roll_out  = cfg_q.invert_roll  ? -roll_fold : roll_fold;
    pitch_out = cfg_q.invert_pitch ? -pitch_q   : pitch_q;

    // open intervals; on a bound or beyond half a circle hold the previous quadrant
    priority if (yaw_q > -HalfCircle && yaw_q < -QuarterCircle) begin
      quad_d = Quad1;
    end else if (yaw_q > -QuarterCircle && yaw_q < 0) begin
      quad_d = Quad2;
    end else if (yaw_q > 0 && yaw_q < QuarterCircle) begin
      quad_d = Quad3;
    end else if (yaw_q > QuarterCircle && yaw_q < HalfCircle) begin
      quad_d = Quad4;
    end else begin
      quad_d = quad_q;
    end

    turn_d = turn_q;
    if (quad_q == Quad4 && quad_d == Quad1) begin
      if (turn_q < TurnLimit) turn_d = turn_q + 8'sd1;
    end else if (quad_q == Quad1 && quad_d == Quad4) begin
      if (turn_q > -TurnLimit) turn_d = turn_q - 8'sd1;
    end

    init_eff = first_q ? init_yaw_q : yaw_q;
    uy_raw   = UyW'(yaw_q) - UyW'(init_eff) + UyW'(turn_d) * FullCircle;
    uy_out   = cfg_q.invert_yaw ? -uy_raw : uy_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= 1'b0;
      init_yaw_q <= '0;
      quad_q     <= QuadNone;
      turn_q     <= '0;
    end else if (step) begin
      first_q    <= 1'b1;
      init_yaw_q <= init_eff;
      quad_q     <= quad_d;
      turn_q     <= turn_d;
    end
  end

  // ---------------- result register ----------------
  logic [63:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {3'b000, turn_d, uy_out, pitch_out, roll_out};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------- assertions ----------------
  a_turn_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    turn_q != -8'sd128)
    else $error("turn count left its saturation range");

  a_turn_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(turn_q) && $stable(quad_q) && $stable(init_yaw_q))
    else $error("unwrap state moved without a beat");

  a_turn_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && quad_q == Quad4 && quad_d == Quad1 && turn_q != TurnLimit
    |=> turn_q == $past(turn_q) + 8'sd1)
    else $error("wrap from fourth to first quadrant did not add a turn");

  a_first_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> first_q)
    else $error("first sample not captured");

endmodule

`default_nettype wire

[hdl/eayu_deg_conv.sv]
// Radian to 1/64-degree conversion: constant multiply, round half up, floor shift.
// Depends on eayu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module eayu_deg_conv (
  input  logic signed [eayu_pkg::RadW-1:0] rad_i,
  output logic signed [eayu_pkg::DegW-1:0] deg_o
);
  import eayu_pkg::*;

  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] rounded;
  logic signed [ProdW-1:0] shifted;

  always_comb begin
    prod    = ProdW'($signed(rad_i)) * ProdW'(DegMul);
    rounded = prod + RoundHalf;
    // arithmetic shift floors toward minus infinity
    shifted = rounded >>> DegShift;
  end

  // |deg| stays below 2^14 for every input word
  assign deg_o = shifted[DegW-1:0];

endmodule

`default_nettype wire

[tb/sv/tb_euler_angle_yaw_unwrapper.sv]
// Self-checking bench for euler_angle_yaw_unwrapper: own attitude predictor, stream driver,
// result checker and random idling on both sides. Depends on eayu_pkg and the block only.
`timescale 1ns / 1ps

module tb_euler_angle_yaw_unwrapper;
  import eayu_pkg::*;

  localparam int CycleLimit = 250000;
  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;  // unmapped index, write must be dropped

  typedef struct packed {
    logic [2:0]  pad;
    logic [7:0]  turns;
    logic [22:0] yaw_unwrapped;
    logic [14:0] pitch;
    logic [14:0] roll;
  } attitude_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CfgInvertRoll;
  logic [0:0] cfg_data_i = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // roll_rad, pitch_rad, yaw_rad
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b1;
  logic [63:0] m_axis_tdata;       // roll_deg, pitch_deg, yaw_unwrapped_deg, turn_count, zero

  // predictor state
  bit inv_roll, inv_pitch, inv_yaw;
  bit yaw_captured;
  int yaw_origin;
  logic [QuadW-1:0] cur_quad = QuadNone;
  int turn_total;

  attitude_beat_t pending_attitudes[$];
  attitude_beat_t got_beat, want_beat;
  int err_count;
  int idle_pct = 12;
  int cycle_count;

  euler_angle_yaw_unwrapper dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int rad_to_deg(input logic signed [15:0] rad);
    longint prod;
    prod = longint'(rad) * longint'(DegMul) + (longint'(1) <<< (DegShift - 1));
    return int'(prod >>> DegShift);
  endfunction

  function automatic void unwrap_sample(input logic signed [15:0] roll_rad,
                                        input logic signed [15:0] pitch_rad,
                                        input logic signed [15:0] yaw_rad);
    int roll, pitch, yaw, half, quarter;
    logic [QuadW-1:0] prev_quad;
    longint uy;
    attitude_beat_t beat;
    half = int'(HalfCircle);
    quarter = int'(QuarterCircle);
    roll = rad_to_deg(roll_rad);
    pitch = rad_to_deg(pitch_rad);
    yaw = rad_to_deg(yaw_rad);
    roll = (roll > 0) ? (half - roll) : (-half - roll);
    if (inv_roll) roll = -roll;
    if (inv_pitch) pitch = -pitch;
    if (!yaw_captured) begin
      yaw_origin = yaw;
      yaw_captured = 1'b1;
    end
    // open quadrants; a yaw on a bound or beyond half a circle keeps the last one
    prev_quad = cur_quad;
    if (yaw > -half && yaw < -quarter) cur_quad = Quad1;
    else if (yaw > -quarter && yaw < 0) cur_quad = Quad2;
    else if (yaw > 0 && yaw < quarter) cur_quad = Quad3;
    else if (yaw > quarter && yaw < half) cur_quad = Quad4;
    if (prev_quad == Quad4 && cur_quad == Quad1) begin
      if (turn_total < int'(TurnLimit)) turn_total++;
    end else if (prev_quad == Quad1 && cur_quad == Quad4) begin
      if (turn_total > -int'(TurnLimit)) turn_total--;
    end
    uy = longint'(yaw) - yaw_origin + longint'(turn_total) * longint'(FullCircle);
    if (inv_yaw) uy = -uy;
    beat.pad = '0;
    beat.roll = roll[14:0];
    beat.pitch = pitch[14:0];
    beat.yaw_unwrapped = uy[22:0];
    beat.turns = turn_total[7:0];
    pending_attitudes.push_back(beat);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s, got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_beat = m_axis_tdata;
      if (pending_attitudes.size() == 0) begin
        report_mismatch("beat with nothing pending", longint'(m_axis_tdata), 0);
      end else begin
        want_beat = pending_attitudes.pop_front();
        if (got_beat.roll != want_beat.roll)
          report_mismatch("roll_deg", $signed(got_beat.roll), $signed(want_beat.roll));
        if (got_beat.pitch != want_beat.pitch)
          report_mismatch("pitch_deg", $signed(got_beat.pitch), $signed(want_beat.pitch));
        if (got_beat.yaw_unwrapped != want_beat.yaw_unwrapped)
          report_mismatch("yaw_unwrapped_deg", $signed(got_beat.yaw_unwrapped),
                          $signed(want_beat.yaw_unwrapped));
        if (got_beat.turns != want_beat.turns)
          report_mismatch("turn_count", $signed(got_beat.turns), $signed(want_beat.turns));
        if (got_beat.pad != want_beat.pad)
          report_mismatch("padding", got_beat.pad, want_beat.pad);
      end
    end
  end

  // result side back-pressure in bursts
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic signed [15:0] roll, input logic signed [15:0] pitch,
                             input logic signed [15:0] yaw);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {yaw, pitch, roll};
    do @(posedge clk_i); while (!s_axis_tready);
    unwrap_sample(roll, pitch, yaw);
  endtask

  // hold the input until every pending result is out and the pipeline is empty
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_attitudes.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_regs(input bit roll_bit, input bit pitch_bit, input bit yaw_bit,
                            input bit poke_unmapped);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CfgInvertRoll;
    cfg_data_i <= roll_bit;
    @(posedge clk_i);
    cfg_index_i <= CfgInvertPitch;
    cfg_data_i <= pitch_bit;
    @(posedge clk_i);
    cfg_index_i <= CfgInvertYaw;
    cfg_data_i <= yaw_bit;
    @(posedge clk_i);
    if (poke_unmapped) begin
      cfg_index_i <= CfgNoReg;
      cfg_data_i <= ~yaw_bit;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    inv_roll = roll_bit;
    inv_pitch = pitch_bit;
    inv_yaw = yaw_bit;
  endtask

  function automatic logic [15:0] rand_angle();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 51472)) - 25736);
  endfunction

  function automatic logic [15:0] yaw_in(input logic [QuadW-1:0] quad);
    case (quad)
      Quad1: return 16'(-int'($urandom_range(13500, 25000)));
      Quad2: return 16'(-int'($urandom_range(500, 12000)));
      Quad3: return 16'($urandom_range(500, 12000));
      default: return 16'($urandom_range(13500, 25000));
    endcase
  endfunction

  // first sample capture, zero roll, quadrant bounds, out-of-range inputs, bit patterns
  task automatic test_directed_extremes();
    send_sample(16'sd0, 16'sd0, 16'sd5000);
    send_sample(16'sd1, -16'sd1, 16'sd0);
    send_sample(-16'sd1, 16'sd1, 16'sd12868);
    send_sample(16'sd25736, -16'sd25736, -16'sd12868);
    send_sample(-16'sd25736, 16'sd25736, 16'sd25736);
    send_sample(16'sh7fff, 16'sh8000, -16'sd25736);
    send_sample(16'sh8000, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh5555, 16'shaaaa, 16'sh8000);
    send_sample(16'shaaaa, 16'sh5555, 16'sd20000);
    send_sample(16'sd0, 16'sd0, -16'sd20000);
    send_sample(16'sd0, 16'sd0, 16'sd20000);
    send_sample(16'sd0, 16'sd0, -16'sd6000);
    send_sample(16'sd100, -16'sd100, 16'sd6000);
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd12867);
    send_sample(16'shffff, 16'sd0, -16'sd12867);
  endtask

  task automatic test_register_settings();
    settle_idle();
    write_regs(1'b1, 1'b1, 1'b1, 1'b1);
    send_sample(16'sd0, 16'sh8000, 16'sh7fff);
    for (int i = 0; i < 14; i++) send_sample(rand_angle(), rand_angle(), rand_angle());
    settle_idle();
    write_regs(1'b1, 1'b0, 1'b1, 1'b0);
    for (int i = 0; i < 14; i++) send_sample(rand_angle(), rand_angle(), rand_angle());
    settle_idle();
    write_regs(1'b0, 1'b1, 1'b0, 1'b1);
    for (int i = 0; i < 14; i++) send_sample(rand_angle(), rand_angle(), rand_angle());
    settle_idle();
    write_regs(1'b0, 1'b0, 1'b0, 1'b0);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh8000);
    for (int i = 0; i < 10; i++) send_sample(rand_angle(), rand_angle(), rand_angle());
  endtask

  // full rotations one way to the positive limit, then back past the negative one
  task automatic test_turn_saturation();
    for (int n = 0; n < 132; n++) begin
      if (n == 66) begin
        settle_idle();
        write_regs(1'b1, 1'b0, 1'b1, 1'b0);
      end
      send_sample(rand_angle(), rand_angle(), yaw_in(Quad4));
      send_sample(rand_angle(), rand_angle(), yaw_in(Quad1));
      send_sample(rand_angle(), rand_angle(),
                  ($urandom_range(0, 31) == 0) ? rand_angle() : yaw_in(Quad3));
    end
    for (int n = 0; n < 262; n++) begin
      idle_pct = (n < 40) ? 0 : 12;
      if (n == 140) begin
        settle_idle();
        write_regs(1'b0, 1'b1, 1'b0, 1'b1);
      end
      send_sample(rand_angle(), rand_angle(), yaw_in(Quad1));
      send_sample(rand_angle(), rand_angle(), yaw_in(Quad4));
      send_sample(rand_angle(), rand_angle(),
                  ($urandom_range(0, 31) == 0) ? rand_angle() : yaw_in(Quad2));
    end
  endtask

  task automatic test_random_noise();
    idle_pct = 20;
    for (int i = 0; i < 80; i++) send_sample(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_steady_stream();
    settle_idle();
    write_regs(1'b1, 1'b1, 1'b0, 1'b0);
    idle_pct = 0;
    for (int i = 0; i < 60; i++) send_sample(rand_angle(), rand_angle(), rand_angle());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_register_settings();
    test_turn_saturation();
    test_random_noise();
    test_steady_stream();
    settle_idle();
    if (err_count == 0 && pending_attitudes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
hdl/eayu_pkg.sv
hdl/eayu_deg_conv.sv
hdl/euler_angle_yaw_unwrapper.sv
tb/sv/tb_euler_angle_yaw_unwrapper.sv
